>>> sv/rcp_pkg.sv
// Package: shared types, state codes and template table for the parser.
package rcp_pkg;

   localparam int ArgWidth = 42;
   localparam int QueueDepthDefault = 2;
   localparam int TmplLen = 16;

   typedef enum logic [3:0] {
      PH_NONE   = 4'd0,
      PH_PIPE   = 4'd1,
      PH_LEVEL  = 4'd2,
      PH_CMD    = 4'd3,
      PH_ARGS   = 4'd4,
      PH_CONT   = 4'd5,
      PH_DONE   = 4'd6,
      PH_BROKEN = 4'd7,
      PH_NEXT   = 4'd8
   } phase_type;

   localparam logic CMD_PARSE   = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef struct packed {
      logic       command;
      logic [7:0] byte_in;
      logic       at_line_start;
      logic [3:0] restart_state;
   } req_type;

   // Result beat: one per request beat.
   typedef struct packed {
      logic [3:0]          parser_state;
      logic                command_found;
      logic [7:0]          command_level;
      logic [7:0]          command_letter;
      logic                arg_valid;
      logic [ArgWidth-1:0] arg_value;
      logic [1:0]          text_count;
      logic [7:0]          text_first;
      logic [7:0]          text_second;
   } rsp_type;

   // Classified beat handed from the front end to the back end.
   typedef struct packed {
      logic       restart;
      logic [3:0] restart_state;
      logic [7:0] byte_in;
      logic       col0;
      logic       is_digit10;
      logic [5:0] b36;
      logic       b36_ok;
      logic       is_eol;
      logic       is_cr;
      logic       is_lf;
   } item_type;

   // Template: length plus up to 16 element characters.
   typedef struct packed {
      logic       found;
      logic [4:0] len;
      logic [TmplLen-1:0][7:0] el;
   } tmpl_type;

   function automatic tmpl_type mk(input string s);
      tmpl_type t;
      t = '0;
      t.found = 1'b1;
      t.len = 5'(s.len());
      for (int i = 0; i < TmplLen; i++) begin
         if (i < s.len()) t.el[i] = s[i];
      end
      return t;
   endfunction

   function automatic tmpl_type find_template(input logic [7:0] lvl, input logic [7:0] c);
      tmpl_type t;
      t = '0;
      if (lvl == 8'd0) begin
         case (c)
            "*", "e", "E", "H", ">", "#": t = mk("");
            "c", "W": t = mk("2");
            "m", "g", "a", "X", "S": t = mk("22");
            "F", "C": t = mk("222");
            "=": t = mk("242");
            "v", "Y", "L", "R", "B", "o": t = mk("2222");
            "A", "I": t = mk("22222");
            "i", "V", "O": t = mk("222222");
            "w": t = mk("222211");
            "s", "Z": t = mk("222222222");
            "Q": t = mk("2222222222222222");
            "T": t = mk("T");
            "@": t = mk("22T");
            "P", "p", "l": t = mk("2*22");
            default: t = '0;
         endcase
      end else if (lvl == 8'd1) begin
         case (c)
            "K", "E": t = mk("");
            "t", "W": t = mk("1T");
            "R": t = mk("8T");
            8'h1b: t = mk("13T");
            "F": t = mk("24t1");
            "D": t = mk("32T");
            "P": t = mk("2221");
            "T": t = mk("22222");
            "C": t = mk("22221");
            "G": t = mk("222222");
            "I": t = mk("22212T");
            "M": t = mk("22222115T");
            "U": t = mk("2222211t3");
            "B": t = mk("222422222222226");
            default: t = '0;
         endcase
      end else if (lvl == 8'd9 && c == 8'h1b) begin
         t = mk("1124T");
      end
      return t;
   endfunction

endpackage

>>> sv/rip_command_parser.sv
// Top level: command-line parser with decoupled classifier and parser engine.
//
//  Channel  | Ports                           | Beat
//  request  | req_valid/req_ready/req_data    | one byte, line-start flag, restart
//  response | rsp_valid/rsp_ready/rsp_data    | one result per request beat
//
// One beat is accepted per cycle unless stalled; a result passes the classifier
// register, queue RAM write and registered read, and parser step into the result
// register. The engine takes a beat a cycle unless stalled (single state update).
// Reset is synchronous and returns the parser to its idle scan state.
// Either side may stall; the queue absorbs beats while the response side waits.
module rip_command_parser #(
   parameter int QueueDepth = rcp_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rcp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcp_pkg::rsp_type  rsp_data
);

   logic              f_valid, f_ready, b_valid, b_ready;
   rcp_pkg::item_type f_item, b_item;

   rcp_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .item_valid(f_valid), .item_ready(f_ready), .item_data(f_item)
   );

   rcp_queue #(.Width($bits(rcp_pkg::item_type)), .Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready),
      .in_data(f_item), .out_valid(b_valid), .out_ready(b_ready), .out_data(b_item)
   );

   rcp_back u_back (
      .clock(clock), .reset(reset), .item_valid(b_valid), .item_ready(b_ready),
      .item_data(b_item), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

>>> sv/rcp_ram.sv
// Generic RAM: one write port, one registered read port.
module rcp_ram #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> sv/rcp_front.sv
// Front end: accepts request beats and classifies the byte.
module rcp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rcp_pkg::req_type  req_data,
   output logic              item_valid,
   input  logic              item_ready,
   output rcp_pkg::item_type item_data
);

   logic              valid_ff, valid_in;
   rcp_pkg::item_type item_ff, item_in;
   logic [7:0]        c;

   assign c = req_data.byte_in;
   assign req_ready = !valid_ff || item_ready;

   // Character classification.
   always_comb begin
      item_in = '0;
      item_in.restart = (req_data.command == rcp_pkg::CMD_RESTART);
      item_in.restart_state = req_data.restart_state;
      item_in.byte_in = c;
      item_in.col0 = req_data.at_line_start;
      item_in.is_digit10 = (c >= "0" && c <= "9");
      item_in.is_cr = (c == 8'h0d);
      item_in.is_lf = (c == 8'h0a);
      item_in.is_eol = item_in.is_cr || item_in.is_lf;
      if (c >= "0" && c <= "9") begin
         item_in.b36 = 6'(c - "0");
         item_in.b36_ok = 1'b1;
      end else if (c >= "A" && c <= "Z") begin
         item_in.b36 = 6'(c - "A" + 8'd10);
         item_in.b36_ok = 1'b1;
      end else if (c >= "a" && c <= "z") begin
         item_in.b36 = 6'(c - "a" + 8'd10);
         item_in.b36_ok = 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (req_valid && req_ready) item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item_data = item_ff;

endmodule

>>> sv/rcp_queue.sv
// Short queue between front and back ends, built on the generic RAM.
module rcp_queue #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [Width-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [Width-1:0] out_data
);

   localparam int AW = $clog2(Depth);

   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in, rd_addr;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          ov_ff, ov_in;
   logic          push, pop, fetch;
   logic [Width-1:0] ram_q, hold_ff, hold_in;
   logic          use_ram_ff;

   // The RAM count excludes the beat in the output register.
   assign in_ready = (cnt_ff < (AW+1)'(Depth));
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign fetch = (cnt_ff != '0) && (!ov_ff || pop);
   assign rd_addr = rd_ff;

   rcp_ram #(.Width(Width), .Depth(Depth)) u_ram (
      .clock(clock), .wr_en(push), .wr_addr(wr_ff), .wr_data(in_data),
      .rd_addr(rd_addr), .rd_data(ram_q)
   );

   always_comb begin
      wr_in = push ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in = fetch ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(fetch);
      ov_in = fetch ? 1'b1 : (pop ? 1'b0 : ov_ff);
      hold_in = use_ram_ff ? ram_q : hold_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
         ov_ff <= 1'b0;
         use_ram_ff <= 1'b0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
         ov_ff <= ov_in;
         use_ram_ff <= fetch;
      end
      hold_ff <= hold_in;
   end

   assign out_valid = ov_ff;
   assign out_data = use_ram_ff ? ram_q : hold_ff;

endmodule

>>> sv/rcp_back.sv
// Back end: the parser state machine and the result register.
module rcp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_ready,
   input  rcp_pkg::item_type item_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rcp_pkg::rsp_type  rsp_data
);

   localparam int ArgWidth = rcp_pkg::ArgWidth;
   localparam logic [7:0] BSL = 8'h5c;

   rcp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  level_ff, level_in, cmd_ff, cmd_in, prev_ff, prev_in;
   logic [4:0]  pos_ff, pos_in, rstart_ff, rstart_in;
   logic [10:0] rleft_ff, rleft_in;
   logic [3:0]  dleft_ff, dleft_in;
   logic [ArgWidth-1:0] acc_ff, acc_in;
   logic        cr_ff, cr_in, lf_ff, lf_in;
   rcp_pkg::tmpl_type tp, lk;
   logic        take;

   // Result register.
   logic        ov_ff;
   logic [3:0]  o_state_ff, o_state_in;
   logic        o_found_ff, o_found_in, o_argv_ff, o_argv_in;
   logic [ArgWidth-1:0] o_aval_ff, o_aval_in;
   logic [1:0]  o_tc_ff, o_tc_in;
   logic [7:0]  o_t1_ff, o_t1_in, o_t2_ff, o_t2_in;

   assign item_ready = !ov_ff || rsp_ready;
   assign take = item_valid && item_ready;

   // Template of the current command and of the incoming letter.
   assign tp = rcp_pkg::find_template(level_ff, cmd_ff);
   assign lk = rcp_pkg::find_template(level_ff, item_data.byte_in);

   // Parser step.
   always_comb begin
      logic [7:0] c;
      logic       eol, more, do_args;
      logic [7:0] k, nextc;
      logic [11:0] nl;
      logic [ArgWidth-1:0] val, nrep;
      logic [4:0] p1;
      phase_in = phase_ff; level_in = level_ff; cmd_in = cmd_ff; prev_in = prev_ff;
      pos_in = pos_ff; rstart_in = rstart_ff; rleft_in = rleft_ff; dleft_in = dleft_ff;
      acc_in = acc_ff; cr_in = cr_ff; lf_in = lf_ff;
      o_found_in = 1'b0; o_argv_in = 1'b0; o_aval_in = '0;
      o_tc_in = '0; o_t1_in = '0; o_t2_in = '0;
      c = item_data.byte_in;
      eol = item_data.is_eol;
      do_args = 1'b0; k = '0; nextc = '0; more = 1'b0;
      nl = '0; val = '0; nrep = '0; p1 = '0;
      if (item_data.restart) begin
         level_in = '0; cmd_in = '0; prev_in = '0; pos_in = '0; rstart_in = '0;
         rleft_in = '0; dleft_in = '0; acc_in = '0; cr_in = 1'b0; lf_in = 1'b0;
         phase_in = (item_data.restart_state > 4'd8) ? rcp_pkg::PH_BROKEN
                  : rcp_pkg::phase_type'(item_data.restart_state);
      end else begin
         unique case (phase_ff)
            rcp_pkg::PH_NONE: begin
               if ((c == "!" && item_data.col0) || c == 8'd1 || c == 8'd2)
                  phase_in = rcp_pkg::PH_PIPE;
            end
            rcp_pkg::PH_PIPE: begin
               if (c == "|") phase_in = rcp_pkg::PH_LEVEL;
               else if (!item_data.is_cr) phase_in = rcp_pkg::PH_DONE;
            end
            rcp_pkg::PH_LEVEL, rcp_pkg::PH_CMD: begin
               if (phase_ff == rcp_pkg::PH_LEVEL && item_data.is_digit10) begin
                  nl = 12'(level_ff) * 12'd10 + 12'(item_data.b36);
                  level_in = (nl > 12'd255) ? 8'd255 : nl[7:0];
               end else begin
                  cmd_in = c;
                  if (!lk.found) phase_in = rcp_pkg::PH_BROKEN;
                  else begin
                     o_found_in = 1'b1;
                     if (lk.len != '0) phase_in = rcp_pkg::PH_ARGS;
                     else begin
                        prev_in = '0;
                        phase_in = rcp_pkg::PH_DONE;
                     end
                  end
               end
            end
            rcp_pkg::PH_ARGS: do_args = 1'b1;
            rcp_pkg::PH_CONT: begin
               phase_in = rcp_pkg::PH_ARGS;
               if (!cr_ff && item_data.is_cr) begin
                  c = '0; cr_in = 1'b1;
               end else if (!lf_ff && item_data.is_lf) begin
                  c = '0; lf_in = 1'b1;
               end
               do_args = !(c == 8'd0 && cr_in && lf_in);
               eol = (c == 8'h0d || c == 8'h0a);
            end
            default: ;
         endcase

         if (do_args) begin
            if (!tp.found || pos_ff >= tp.len) begin
               phase_in = rcp_pkg::PH_BROKEN;
            end else begin
               k = tp.el[pos_ff[3:0]];
               p1 = pos_ff + 5'd1;
               more = (p1 < tp.len) || (rleft_ff != '0 && rstart_ff < tp.len);
               nextc = (p1 < tp.len) ? tp.el[p1[3:0]] : 8'd0;
               if (k >= "0" && k <= "9") begin
                  if (dleft_ff == '0) dleft_in = 4'(k - "0");
                  if (item_data.b36_ok && c != 8'd0) begin
                     acc_in = ArgWidth'(acc_ff * ArgWidth'(36) + ArgWidth'(item_data.b36));
                     dleft_in = dleft_in - 4'd1;
                  end else if (prev_ff == BSL && eol) begin
                     phase_in = rcp_pkg::PH_CONT;
                     cr_in = (c == 8'h0d); lf_in = (c == 8'h0a);
                  end else if (c == BSL) begin
                     if (prev_ff == BSL) phase_in = rcp_pkg::PH_BROKEN;
                  end else if (more) begin
                     phase_in = rcp_pkg::PH_BROKEN;
                  end else begin
                     o_argv_in = 1'b1; o_aval_in = acc_ff; acc_in = '0;
                     if (c == "|") phase_in = rcp_pkg::PH_NEXT;
                     else begin
                        prev_in = c; phase_in = rcp_pkg::PH_DONE;
                     end
                  end
                  if (dleft_in == '0) begin
                     val = acc_in;
                     o_argv_in = 1'b1; o_aval_in = acc_in; acc_in = '0;
                     // Advance through the template, handling the repeat marker.
                     pos_in = p1;
                     if (p1 < tp.len && tp.el[p1[3:0]] == "*") begin
                        nrep = (val != '0) ? val - 1'b1 : '0;
                        rleft_in = (nrep > ArgWidth'(2047)) ? 11'd2047 : nrep[10:0];
                        rstart_in = p1 + 5'd1;
                        pos_in = rstart_in;
                     end
                     if (pos_in >= tp.len && rleft_in != '0 && rstart_in < tp.len) begin
                        rleft_in = rleft_in - 11'd1;
                        pos_in = rstart_in;
                     end
                     if (pos_in >= tp.len) begin
                        prev_in = '0;
                        phase_in = rcp_pkg::PH_DONE;
                     end
                  end
               end else if (k == "t" || k == "T") begin
                  if (k == "t" && prev_ff == "<" && c == ">") begin
                     dleft_in = dleft_ff + 4'd1;
                     if (8'(dleft_in) + "0" == nextc) begin
                        prev_in = '0; phase_in = rcp_pkg::PH_DONE;
                     end
                  end else if (prev_ff == BSL) begin
                     if (eol) begin
                        phase_in = rcp_pkg::PH_CONT;
                        cr_in = (c == 8'h0d); lf_in = (c == 8'h0a);
                     end else begin
                        o_tc_in = 2'd1; o_t1_in = c;
                     end
                  end else if (c == BSL) begin
                  end else if (eol) begin
                     prev_in = c; phase_in = rcp_pkg::PH_DONE;
                  end else if (c == "|") begin
                     phase_in = rcp_pkg::PH_NEXT;
                  end else if (k == "t") begin
                     if (prev_ff == "<") begin
                        o_tc_in = 2'd1; o_t1_in = "<";
                        if (c != "<") begin
                           o_tc_in = 2'd2; o_t2_in = c;
                        end
                     end else if (c != "<") begin
                        o_tc_in = 2'd1; o_t1_in = c;
                     end
                  end else begin
                     o_tc_in = 2'd1; o_t1_in = c;
                  end
               end else begin
                  phase_in = rcp_pkg::PH_BROKEN;
               end
            end
         end
         if (phase_in != rcp_pkg::PH_DONE) prev_in = c;
      end
      o_state_in = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rcp_pkg::PH_NONE;
         level_ff <= '0; cmd_ff <= '0; prev_ff <= '0; pos_ff <= '0; rstart_ff <= '0;
         rleft_ff <= '0; dleft_ff <= '0; acc_ff <= '0; cr_ff <= 1'b0; lf_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; level_ff <= level_in; cmd_ff <= cmd_in;
            prev_ff <= prev_in; pos_ff <= pos_in; rstart_ff <= rstart_in;
            rleft_ff <= rleft_in; dleft_ff <= dleft_in; acc_ff <= acc_in;
            cr_ff <= cr_in; lf_ff <= lf_in;
         end
         if (item_ready) ov_ff <= item_valid;
      end
      if (take) begin
         o_state_ff <= o_state_in; o_found_ff <= o_found_in; o_argv_ff <= o_argv_in;
         o_aval_ff <= o_aval_in; o_tc_ff <= o_tc_in; o_t1_ff <= o_t1_in; o_t2_ff <= o_t2_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data.parser_state = o_state_ff;
   assign rsp_data.command_found = o_found_ff;
   assign rsp_data.command_level = level_ff;
   assign rsp_data.command_letter = cmd_ff;
   assign rsp_data.arg_valid = o_argv_ff;
   assign rsp_data.arg_value = o_aval_ff;
   assign rsp_data.text_count = o_tc_ff;
   assign rsp_data.text_first = o_t1_ff;
   assign rsp_data.text_second = o_t2_ff;

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the command-line parser: bursty stimulus, checked results.
`timescale 1ns / 100ps

module testbench;

   localparam int ArgW = rcp_pkg::ArgWidth;
   localparam longint unsigned ArgMask = (64'd1 << ArgW) - 64'd1;
   localparam int IdleLimit = 5000;
   localparam int RandomLines = 96;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rcp_pkg::req_type  req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rcp_pkg::rsp_type  rsp_data;

   rcp_pkg::rsp_type expected_results[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int ready_pct = 100;
   int ready_phase_cycles = 0;

   // Command table of the parser model: level, letters and argument template.
   int    tab_level[29];
   string tab_letters[29];
   string tab_shape[29];

   // Parser model state.
   logic [3:0]        m_phase;
   int                m_level, m_cmd, m_pos, m_rep_start, m_reps, m_digits, m_prev;
   longint unsigned   m_acc;
   bit                m_cr, m_lf;
   rcp_pkg::rsp_type  m_out;

   rip_command_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Fill the command table.
   task automatic load_table();
      int i;
      i = 0;
      tab_level[i] = 0; tab_letters[i] = "*eEH>#"; tab_shape[i] = ""; i++;
      tab_level[i] = 0; tab_letters[i] = "cW"; tab_shape[i] = "2"; i++;
      tab_level[i] = 0; tab_letters[i] = "mgaXS"; tab_shape[i] = "22"; i++;
      tab_level[i] = 0; tab_letters[i] = "FC"; tab_shape[i] = "222"; i++;
      tab_level[i] = 0; tab_letters[i] = "="; tab_shape[i] = "242"; i++;
      tab_level[i] = 0; tab_letters[i] = "vYLRBo"; tab_shape[i] = "2222"; i++;
      tab_level[i] = 0; tab_letters[i] = "AI"; tab_shape[i] = "22222"; i++;
      tab_level[i] = 0; tab_letters[i] = "iVO"; tab_shape[i] = "222222"; i++;
      tab_level[i] = 0; tab_letters[i] = "w"; tab_shape[i] = "222211"; i++;
      tab_level[i] = 0; tab_letters[i] = "sZ"; tab_shape[i] = "222222222"; i++;
      tab_level[i] = 0; tab_letters[i] = "Q"; tab_shape[i] = "2222222222222222"; i++;
      tab_level[i] = 0; tab_letters[i] = "T"; tab_shape[i] = "T"; i++;
      tab_level[i] = 0; tab_letters[i] = "@"; tab_shape[i] = "22T"; i++;
      tab_level[i] = 0; tab_letters[i] = "Ppl"; tab_shape[i] = "2*22"; i++;
      tab_level[i] = 1; tab_letters[i] = "KE"; tab_shape[i] = ""; i++;
      tab_level[i] = 1; tab_letters[i] = "tW"; tab_shape[i] = "1T"; i++;
      tab_level[i] = 1; tab_letters[i] = "R"; tab_shape[i] = "8T"; i++;
      tab_level[i] = 1; tab_letters[i] = "\033"; tab_shape[i] = "13T"; i++;
      tab_level[i] = 1; tab_letters[i] = "F"; tab_shape[i] = "24t1"; i++;
      tab_level[i] = 1; tab_letters[i] = "D"; tab_shape[i] = "32T"; i++;
      tab_level[i] = 1; tab_letters[i] = "P"; tab_shape[i] = "2221"; i++;
      tab_level[i] = 1; tab_letters[i] = "T"; tab_shape[i] = "22222"; i++;
      tab_level[i] = 1; tab_letters[i] = "C"; tab_shape[i] = "22221"; i++;
      tab_level[i] = 1; tab_letters[i] = "G"; tab_shape[i] = "222222"; i++;
      tab_level[i] = 1; tab_letters[i] = "I"; tab_shape[i] = "22212T"; i++;
      tab_level[i] = 1; tab_letters[i] = "M"; tab_shape[i] = "22222115T"; i++;
      tab_level[i] = 1; tab_letters[i] = "U"; tab_shape[i] = "2222211t3"; i++;
      tab_level[i] = 1; tab_letters[i] = "B"; tab_shape[i] = "222422222222226"; i++;
      tab_level[i] = 9; tab_letters[i] = "\033"; tab_shape[i] = "1124T";
   endtask

   // Look up the argument shape for a level and letter.
   function automatic bit shape_of(input int lvl, input int c, output string s);
      s = "";
      for (int i = 0; i < 29; i++) begin
         if (tab_level[i] == lvl) begin
            for (int j = 0; j < tab_letters[i].len(); j++) begin
               if (tab_letters[i][j] == c) begin
                  s = tab_shape[i];
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic int digit36(input int c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "Z") return c - "A" + 10;
      if (c >= "a" && c <= "z") return c - "a" + 10;
      return -1;
   endfunction

   task automatic emit_text(input int b);
      if (m_out.text_count == 0) m_out.text_first = b[7:0];
      else if (m_out.text_count == 1) m_out.text_second = b[7:0];
      if (m_out.text_count < 2) m_out.text_count++;
   endtask

   task automatic emit_arg();
      m_out.arg_valid = 1'b1;
      m_out.arg_value = m_acc[ArgW-1:0];
      m_acc = 0;
   endtask

   task automatic enter_cont(input int c);
      m_phase = rcp_pkg::PH_CONT;
      m_cr = (c == 13);
      m_lf = (c == 10);
   endtask

   // Step to the next template element, handling the repeat marker.
   task automatic next_element(input string t, input int len, input longint unsigned v);
      longint unsigned n;
      m_pos++;
      if (m_pos < len && t[m_pos] == "*") begin
         n = (v != 0) ? v - 1 : 0;
         m_reps = (n > 2047) ? 2047 : int'(n);
         m_rep_start = m_pos + 1;
         m_pos = m_rep_start;
      end
      if (m_pos >= len && m_reps != 0 && m_rep_start < len) begin
         m_reps--;
         m_pos = m_rep_start;
      end
      if (m_pos >= len) begin
         m_prev = 0;
         m_phase = rcp_pkg::PH_DONE;
      end
   endtask

   // One byte of argument parsing.
   task automatic args_byte(input int c);
      string t;
      bit ok, more, eol;
      int len, k, nextc, v;
      longint unsigned val;
      ok = shape_of(m_level, m_cmd, t);
      len = ok ? t.len() : 0;
      eol = (c == 13 || c == 10);
      if (!ok || m_pos >= len) begin
         m_phase = rcp_pkg::PH_BROKEN;
         return;
      end
      k = t[m_pos];
      more = (m_pos + 1 < len) || (m_reps != 0 && m_rep_start < len);
      nextc = (m_pos + 1 < len) ? int'(t[m_pos + 1]) : 0;
      if (k >= "0" && k <= "9") begin
         v = digit36(c);
         if (m_digits == 0) m_digits = k - "0";
         if (v >= 0) begin
            m_acc = (m_acc * 36 + longint'(v)) & ArgMask;
            m_digits = (m_digits - 1) & 15;
         end else if (m_prev == "\\" && eol) begin
            enter_cont(c);
         end else if (c == "\\") begin
            if (m_prev == "\\") m_phase = rcp_pkg::PH_BROKEN;
         end else if (more) begin
            m_phase = rcp_pkg::PH_BROKEN;
         end else begin
            emit_arg();
            if (c == "|") m_phase = rcp_pkg::PH_NEXT;
            else begin
               m_prev = c;
               m_phase = rcp_pkg::PH_DONE;
            end
         end
         if (m_digits == 0) begin
            val = m_acc & ArgMask;
            emit_arg();
            next_element(t, len, val);
         end
      end else if (k == "t" || k == "T") begin
         if (k == "t" && m_prev == "<" && c == ">") begin
            m_digits = (m_digits + 1) & 15;
            if (m_digits + "0" == nextc) begin
               m_prev = 0;
               m_phase = rcp_pkg::PH_DONE;
            end
         end else if (m_prev == "\\") begin
            if (eol) enter_cont(c);
            else emit_text(c);
         end else if (c == "\\") begin
            // Escape lead-in: nothing emitted yet.
         end else if (eol) begin
            m_prev = c;
            m_phase = rcp_pkg::PH_DONE;
         end else if (c == "|") begin
            m_phase = rcp_pkg::PH_NEXT;
         end else if (k == "t") begin
            if (m_prev == "<") emit_text("<");
            if (c != "<") emit_text(c);
         end else begin
            emit_text(c);
         end
      end else begin
         m_phase = rcp_pkg::PH_BROKEN;
      end
   endtask

   task automatic clear_model();
      m_phase = rcp_pkg::PH_NONE;
      m_level = 0; m_cmd = 0; m_pos = 0; m_rep_start = 0;
      m_reps = 0; m_digits = 0; m_prev = 0; m_acc = 0;
      m_cr = 0; m_lf = 0;
   endtask

   // Predict the result of one accepted beat.
   task automatic predict_parse(input rcp_pkg::req_type r);
      int c, nl;
      string t;
      bit ok;
      c = r.byte_in;
      m_out = '0;
      if (r.command == rcp_pkg::CMD_RESTART) begin
         clear_model();
         m_phase = (r.restart_state > 8) ? 4'(rcp_pkg::PH_BROKEN) : r.restart_state;
      end else begin
         case (m_phase)
            rcp_pkg::PH_NONE: begin
               if ((c == "!" && r.at_line_start) || c == 1 || c == 2)
                  m_phase = rcp_pkg::PH_PIPE;
            end
            rcp_pkg::PH_PIPE: begin
               if (c == "|") m_phase = rcp_pkg::PH_LEVEL;
               else if (c != 13) m_phase = rcp_pkg::PH_DONE;
            end
            rcp_pkg::PH_LEVEL, rcp_pkg::PH_CMD: begin
               if (m_phase == rcp_pkg::PH_LEVEL && c >= "0" && c <= "9") begin
                  nl = m_level * 10 + (c - "0");
                  m_level = (nl > 255) ? 255 : nl;
               end else begin
                  ok = shape_of(m_level, c, t);
                  m_cmd = c;
                  if (!ok) m_phase = rcp_pkg::PH_BROKEN;
                  else begin
                     m_out.command_found = 1'b1;
                     if (t.len() > 0) m_phase = rcp_pkg::PH_ARGS;
                     else begin
                        m_prev = 0;
                        m_phase = rcp_pkg::PH_DONE;
                     end
                  end
               end
            end
            rcp_pkg::PH_ARGS: args_byte(c);
            rcp_pkg::PH_CONT: begin
               if (!m_cr && c == 13) begin
                  c = 0;
                  m_cr = 1;
               end else if (!m_lf && c == 10) begin
                  c = 0;
                  m_lf = 1;
               end
               m_phase = rcp_pkg::PH_ARGS;
               if (!(c == 0 && m_cr && m_lf)) args_byte(c);
            end
            default: ;
         endcase
         if (m_phase != rcp_pkg::PH_DONE) m_prev = c & 255;
      end
      m_out.parser_state = m_phase;
      m_out.command_level = m_level[7:0];
      m_out.command_letter = m_cmd[7:0];
   endtask

   // Send one beat; the sender runs in bursts with random gaps between them.
   task automatic send_beat(input logic cmd, input int b, input logic col0, input int rs);
      rcp_pkg::req_type r;
      r.command = cmd;
      r.byte_in = b[7:0];
      r.at_line_start = col0;
      r.restart_state = rs[3:0];
      if (burst_left == 0) begin
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      predict_parse(r);
      expected_results.push_back(m_out);
   endtask

   task automatic send_byte(input int b);
      send_beat(rcp_pkg::CMD_PARSE, b, $urandom_range(0, 1), $urandom_range(0, 15));
   endtask

   task automatic send_restart(input int rs);
      send_beat(rcp_pkg::CMD_RESTART, $urandom_range(0, 255), $urandom_range(0, 1), rs);
   endtask

   function automatic int char36(input int v);
      if (v < 10) return "0" + v;
      return ($urandom_range(0, 1) ? "A" : "a") + v - 10;
   endfunction

   // Send a fixed-width base-36 number, now and then with a continuation inside.
   task automatic send_number(input int width, input int forced);
      int digs[16];
      int v;
      v = forced;
      for (int i = width - 1; i >= 0; i--) begin
         digs[i] = (forced >= 0) ? v % 36 : $urandom_range(0, 35);
         v = v / 36;
      end
      for (int i = 0; i < width; i++) begin
         if ($urandom_range(0, 30) == 0) begin
            send_byte("\\");
            if ($urandom_range(0, 1)) begin
               send_byte(13);
               send_byte(10);
            end else begin
               send_byte(10);
               send_byte(13);
            end
         end
         send_byte(char36(digs[i]));
      end
   endtask

   // Send a run of text for one text element.
   task automatic send_text(input bit counted, input int pairs);
      int n;
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               send_byte("\\");
               send_byte($urandom_range(0, 255));
            end
            1: send_byte("<");
            default: send_byte($urandom_range(32, 126) == "|" ? "a" : $urandom_range(32, 126));
         endcase
      end
      if (counted && pairs > 0 && $urandom_range(0, 3) != 0) begin
         for (int i = 0; i < pairs; i++) begin
            send_byte("<");
            send_byte(">");
         end
      end else begin
         case ($urandom_range(0, 2))
            0: send_byte(13);
            1: send_byte(10);
            default: send_byte("|");
         endcase
      end
   endtask

   task automatic send_elements(input string t, input int from, input int upto);
      for (int i = from; i < upto; i++) begin
         if (t[i] >= "1" && t[i] <= "9") send_number(t[i] - "0", -1);
         else send_text(t[i] == "t", (i + 1 < t.len()) ? t[i + 1] - "0" : 0);
      end
   endtask

   // Send one well-formed command line with random content.
   task automatic send_command_line(input int entry);
      string t;
      int star, copies, lvl;
      t = tab_shape[entry];
      lvl = tab_level[entry];
      send_restart(rcp_pkg::PH_NONE);
      case ($urandom_range(0, 2))
         0: send_beat(rcp_pkg::CMD_PARSE, "!", 1'b1, $urandom_range(0, 15));
         1: send_byte(1);
         default: send_byte(2);
      endcase
      send_byte("|");
      if (lvl != 0 || $urandom_range(0, 1)) send_byte("0" + lvl);
      send_byte(tab_letters[entry][$urandom_range(0, tab_letters[entry].len() - 1)]);
      star = -1;
      for (int i = 0; i < t.len(); i++) if (t[i] == "*") star = i;
      if (star < 0) begin
         send_elements(t, 0, t.len());
      end else begin
         copies = $urandom_range(0, 3);
         send_elements(t, 0, star - 1);
         send_number(t[star - 1] - "0", copies);
         repeat ((copies < 1) ? 1 : copies) send_elements(t, star + 1, t.len());
      end
      if ($urandom_range(0, 3) == 0) send_byte($urandom_range(0, 255));
   endtask

   // Restart into every state code and exercise the lead-in and level rules.
   task automatic test_directed();
      for (int s = 0; s < 16; s++) begin
         send_restart(s);
         send_byte((s == 4 || s == 5) ? "1" : $urandom_range(0, 255));
      end
      // Lead-in rules: bang off column zero is ignored, pipe state tolerates CR.
      send_restart(rcp_pkg::PH_NONE);
      send_beat(rcp_pkg::CMD_PARSE, "!", 1'b0, 0);
      send_beat(rcp_pkg::CMD_PARSE, "!", 1'b1, 0);
      send_byte(13);
      send_byte("|");
      // Level saturation, then an unknown letter.
      send_byte("9");
      send_byte("9");
      send_byte("9");
      send_byte("Q");
      send_restart(rcp_pkg::PH_PIPE);
      send_byte("x");
      send_beat(rcp_pkg::CMD_PARSE, 8'hff, 1'b1, 4'hf);
      send_beat(rcp_pkg::CMD_PARSE, 8'h00, 1'b0, 4'h0);
   endtask

   // Walk every table entry once with well-formed lines.
   task automatic test_each_command();
      for (int e = 0; e < 29; e++) send_command_line(e);
   endtask

   // Mostly well-formed lines, with noise and broken sequences mixed in.
   task automatic test_random_lines();
      for (int i = 0; i < RandomLines; i++) begin
         if ($urandom_range(0, 5) != 0) begin
            send_command_line($urandom_range(0, 28));
         end else begin
            if ($urandom_range(0, 1)) send_restart($urandom_range(0, 15));
            repeat ($urandom_range(1, 12)) send_byte($urandom_range(0, 255));
         end
      end
   endtask

   task automatic report_mismatch(input string field, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $time);
      errors++;
   endtask

   // Receiver stalls, result checks and the idle watchdog.
   always @(posedge clock) begin
      rcp_pkg::rsp_type e;
      if (ready_phase_cycles == 0) begin
         ready_phase_cycles = $urandom_range(20, 300);
         case ($urandom_range(0, 3))
            0: ready_pct = 30;
            1: ready_pct = 70;
            default: ready_pct = 100;
         endcase
      end
      ready_phase_cycles--;
      rsp_ready <= ($urandom_range(0, 99) < ready_pct);
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("testbench: done, errors");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               e = expected_results.pop_front();
               if (rsp_data.parser_state != e.parser_state)
                  report_mismatch("parser_state", rsp_data.parser_state, e.parser_state);
               if (rsp_data.command_found != e.command_found)
                  report_mismatch("command_found", rsp_data.command_found, e.command_found);
               if (rsp_data.command_level != e.command_level)
                  report_mismatch("command_level", rsp_data.command_level, e.command_level);
               if (rsp_data.command_letter != e.command_letter)
                  report_mismatch("command_letter", rsp_data.command_letter,
                                  e.command_letter);
               if (rsp_data.arg_valid != e.arg_valid)
                  report_mismatch("arg_valid", rsp_data.arg_valid, e.arg_valid);
               if (rsp_data.arg_value != e.arg_value)
                  report_mismatch("arg_value", rsp_data.arg_value, e.arg_value);
               if (rsp_data.text_count != e.text_count)
                  report_mismatch("text_count", rsp_data.text_count, e.text_count);
               if (rsp_data.text_first != e.text_first)
                  report_mismatch("text_first", rsp_data.text_first, e.text_first);
               if (rsp_data.text_second != e.text_second)
                  report_mismatch("text_second", rsp_data.text_second, e.text_second);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_ready <= 1'b0;
      load_table();
      clear_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_each_command();
      test_random_lines();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/rcp_pkg.sv
sv/rcp_ram.sv
sv/rcp_front.sv
sv/rcp_queue.sv
sv/rcp_back.sv
sv/rip_command_parser.sv
verif/testbench.sv
